// ===== hw/rtl/ibd_pkg.sv =====
// Package: shared types and constants for the integrating button debounce block.
package ibd_pkg;

  localparam int unsigned LimitBits    = 8;
  localparam int unsigned PhaseBits    = 10;
  localparam int unsigned MsBits       = 10;
  localparam int unsigned DurationBits = 26;
  localparam int unsigned CfgIdxBits   = 2;
  localparam int unsigned CfgDataBits  = 10;

  // Configuration register indexes
  localparam logic [CfgIdxBits-1:0] CFG_INTEGRATE_LIMIT = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_ACTIVE_LEVEL    = 2'd1;
  localparam logic [CfgIdxBits-1:0] CFG_REPORT_INTERVAL = 2'd2;
  localparam logic [CfgIdxBits-1:0] CFG_MS_PER_TICK     = 2'd3;

  // Event kinds
  localparam logic KIND_RELEASED = 1'b0;
  localparam logic KIND_HELD     = 1'b1;

  typedef struct packed {
    logic [LimitBits-1:0] integrate_limit;
    logic                 active_level;
    logic [PhaseBits-1:0] report_interval;
  } ibd_cfg_t;

  typedef struct packed {
    logic [LimitBits-1:0] integ;
    logic                 pressed;
    logic [PhaseBits-1:0] phase;
  } ibd_ctl_t;

  typedef struct packed {
    logic emit;
    logic kind;
    logic pressed;
  } ibd_evt_t;

endpackage

// ===== hw/rtl/ibd_step.sv =====
// Next-state and report decision for one sample tick.
module ibd_step #(
  parameter int unsigned TICK_COUNT_BITS = 16
) (
  input  ibd_pkg::ibd_cfg_t          cfg,
  input  logic                       sample_level,
  input  ibd_pkg::ibd_ctl_t          cur,
  input  logic [TICK_COUNT_BITS-1:0] held_cur,
  output ibd_pkg::ibd_ctl_t          nxt,
  output logic [TICK_COUNT_BITS-1:0] held_nxt,
  output ibd_pkg::ibd_evt_t          evt,
  output logic [TICK_COUNT_BITS-1:0] held_rep
);
  import ibd_pkg::*;

  logic                       sample_pressed;
  logic                       changed;
  logic [LimitBits-1:0]       integ_inc;
  logic [PhaseBits-1:0]       phase_inc;
  logic [TICK_COUNT_BITS-1:0] held_adv;

  always_comb begin
    sample_pressed = (sample_level == cfg.active_level);
    changed        = 1'b0;
    nxt            = cur;
    integ_inc      = cur.integ + LimitBits'(1);

    if (sample_pressed) begin
      if (cur.integ < cfg.integrate_limit) begin
        nxt.integ = integ_inc;
        if (integ_inc >= cfg.integrate_limit) begin
          changed     = !cur.pressed;
          nxt.pressed = 1'b1;
          nxt.integ   = cfg.integrate_limit;
        end
      end
    end else if (cur.integ != '0) begin
      nxt.integ = cur.integ - LimitBits'(1);
      if (cur.integ == LimitBits'(1)) begin
        changed     = cur.pressed;
        nxt.pressed = 1'b0;
      end
    end

    // Count held ticks, saturating, and advance the wrapping report phase
    held_adv  = held_cur;
    phase_inc = cur.phase + PhaseBits'(1);
    if (nxt.pressed) begin
      if (held_cur != '1) begin
        held_adv = held_cur + TICK_COUNT_BITS'(1);
      end
      nxt.phase = (phase_inc >= cfg.report_interval) ? '0 : phase_inc;
    end

    held_nxt    = held_adv;
    held_rep    = held_adv;
    evt.emit    = 1'b0;
    evt.kind    = KIND_RELEASED;
    evt.pressed = nxt.pressed;

    if (changed && !nxt.pressed) begin
      evt.emit  = 1'b1;
      evt.kind  = KIND_RELEASED;
      held_nxt  = '0;
      nxt.phase = '0;
    end else if (nxt.pressed && !changed && nxt.phase == '0) begin
      evt.emit = 1'b1;
      evt.kind = KIND_HELD;
    end
  end

endmodule

// ===== hw/rtl/integrating_button_debounce.sv =====
// Top level: integrating button debouncer with press-duration reports.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+--------------------------------------
//  in_     | in  | in_tvalid / in_tready  | tdata: sample_level
//  out_    | out | out_tvalid / out_tready| tdata: debounced_pressed, duration_ms
//          |     |                        | tuser: event_kind
//  cfg_    | in  | cfg_wr_en              | cfg_index, cfg_wdata
//
// One item is accepted every cycle while in_tready is high; debounce state updates at the accepting edge.
// A report passes through the report register, which loads at its accepting edge, and then
// the output register, which drives out_tvalid and loads when it can advance, after the duration
// multiply (held ticks times ms_per_tick).
// in_tready drops only while both stages are full and out_tready is low.
// rst_n is synchronous; reset loads the register defaults and clears the control state and valid flags.
module integrating_button_debounce #(
  parameter int unsigned TICK_COUNT_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [0] sample_level
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [31:0]                      out_tdata,  // [0] debounced_pressed,
                                                       // [26:1] duration_ms
  output logic                             out_tuser,  // [0] event_kind
  input  logic                             cfg_wr_en,
  input  logic [ibd_pkg::CfgIdxBits-1:0]   cfg_index,
  input  logic [ibd_pkg::CfgDataBits-1:0]  cfg_wdata
);
  import ibd_pkg::*;

  localparam int unsigned ProdRaw  = TICK_COUNT_BITS + MsBits;
  localparam int unsigned ProdBits = (ProdRaw > DurationBits) ? ProdRaw : DurationBits;

  ibd_cfg_t                   cfg_r;
  logic [MsBits-1:0]          ms_per_tick_r;
  ibd_ctl_t                   ctl_r;
  ibd_ctl_t                   ctl_nxt;
  logic [TICK_COUNT_BITS-1:0] held_r;
  logic [TICK_COUNT_BITS-1:0] held_nxt;
  logic [TICK_COUNT_BITS-1:0] held_rep;
  ibd_evt_t                   evt;

  logic                       rep_vld_r;
  logic                       rep_kind_r;
  logic                       rep_pressed_r;
  logic [TICK_COUNT_BITS-1:0] rep_held_r;

  logic                       out_vld_r;
  logic                       out_kind_r;
  logic                       out_pressed_r;
  logic [DurationBits-1:0]    out_dur_r;

  logic                       adv_out;
  logic                       accept;
  logic [ProdBits-1:0]        prod;

  ibd_step #(
    .TICK_COUNT_BITS(TICK_COUNT_BITS)
  ) u_step (
    .cfg          (cfg_r),
    .sample_level (in_tdata[0]),
    .cur          (ctl_r),
    .held_cur     (held_r),
    .nxt          (ctl_nxt),
    .held_nxt     (held_nxt),
    .evt          (evt),
    .held_rep     (held_rep)
  );

  assign adv_out   = !out_vld_r || out_tready;
  assign in_tready = !rep_vld_r || adv_out;
  assign accept    = in_tvalid && in_tready;
  assign prod      = ProdBits'(rep_held_r) * ProdBits'(ms_per_tick_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.integrate_limit <= LimitBits'(10);
      cfg_r.active_level    <= 1'b0;
      cfg_r.report_interval <= PhaseBits'(100);
      ms_per_tick_r         <= MsBits'(10);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_INTEGRATE_LIMIT: cfg_r.integrate_limit <= cfg_wdata[LimitBits-1:0];
        CFG_ACTIVE_LEVEL:    cfg_r.active_level    <= cfg_wdata[0];
        CFG_REPORT_INTERVAL: cfg_r.report_interval <= cfg_wdata[PhaseBits-1:0];
        CFG_MS_PER_TICK:     ms_per_tick_r         <= cfg_wdata[MsBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r     <= '0;
      held_r    <= '0;
      rep_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        ctl_r     <= ctl_nxt;
        held_r    <= held_nxt;
        rep_vld_r <= evt.emit;
      end else if (adv_out) begin
        rep_vld_r <= 1'b0;
      end
      if (adv_out) begin
        out_vld_r <= rep_vld_r;
      end
    end
  end

  // Payload registers: hold while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      rep_kind_r    <= evt.kind;
      rep_pressed_r <= evt.pressed;
      rep_held_r    <= held_rep;
    end
    if (adv_out) begin
      out_kind_r    <= rep_kind_r;
      out_pressed_r <= rep_pressed_r;
      out_dur_r     <= prod[DurationBits-1:0];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {5'b0, out_dur_r, out_pressed_r};

`ifndef SYNTHESIS
  a_held_is_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_HELD |-> out_tdata[0])
    else $error("held report without pressed state");

  a_release_is_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_RELEASED |-> !out_tdata[0])
    else $error("release report with pressed state");

  a_idle_counts_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl_r.pressed |-> held_r == '0 && ctl_r.phase == '0)
    else $error("held count or phase not clear while released");

  a_press_starts_count: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ctl_r.pressed) |-> held_r == TICK_COUNT_BITS'(1))
    else $error("held count wrong on press");
`endif

endmodule
